>>> sv/bps_pkg.sv
// Shared types and constants for the bilinear pixel sampler.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bps_pkg;

  localparam int COORD_W       = 19;   // signed sample coordinate width
  localparam int CFG_W         = 10;   // configuration data width
  localparam int WR_IDX_W      = 9;    // write row and column index width
  localparam int PIX_W         = 8;    // grey pixel width
  localparam int MAX_ROWS_DEF  = 512;
  localparam int MAX_COLS_DEF  = 512;
  localparam int FRAC_BITS_DEF = 8;

  localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 10'd512;

  typedef enum logic [0:0] {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } opcode_t;

  typedef enum logic [0:0] {
    CFG_STORED_ROWS = 1'b0,
    CFG_STORED_COLS = 1'b1
  } cfg_index_t;

endpackage

>>> sv/bilinear_pixel_sampler.sv
// Top level of the bilinear pixel sampler: pipeline, banked image store and blend.
// Depends on bps_pkg, bps_axis and bps_bank.
`timescale 1ns / 1ps
//
//  Channel  Direction  Handshake          Payload
//  in_      input      in_valid/in_stall  opcode, write_row/col/value, sample_row/col
//  out_     output     out_valid/out_stall sample_value
//  cfg_     input      cfg_we             cfg_index, cfg_wdata
//
// One transaction is accepted per cycle while in_stall is low; each stage is registered.
// The four neighbours come from four single-port banks split by row and column parity,
// each doing one read or one write per cycle while its enable is high.
// Reset clears the pipeline valids and sets both sizes to 512; pixels are undefined
// until written. Each stage holds only while the stage after it is full and stalled,
// so in_stall rises only when every stage and the output register are full.

module bilinear_pixel_sampler import bps_pkg::*; #(
  parameter int MAX_ROWS  = MAX_ROWS_DEF,
  parameter int MAX_COLS  = MAX_COLS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,

  input  logic                in_valid,
  output logic                in_stall,
  input  logic [0:0]          in_opcode,
  input  logic [WR_IDX_W-1:0] in_write_row,
  input  logic [WR_IDX_W-1:0] in_write_col,
  input  logic [PIX_W-1:0]    in_write_value,
  input  logic [COORD_W-1:0]  in_sample_row,
  input  logic [COORD_W-1:0]  in_sample_col,

  output logic                out_valid,
  input  logic                out_stall,
  output logic [PIX_W-1:0]    out_sample_value,

  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [CFG_W-1:0]    cfg_wdata
);

  localparam int RIW = $clog2(MAX_ROWS);
  localparam int CIW = $clog2(MAX_COLS);
  localparam int RHW = (RIW > 1) ? RIW - 1 : 1;
  localparam int CHW = (CIW > 1) ? CIW - 1 : 1;
  localparam int AW  = RHW + CHW;
  localparam int WW  = FRAC_BITS + 1;
  localparam int RBW = PIX_W + FRAC_BITS + 1;
  localparam int CBW = RBW + FRAC_BITS + 1;
  localparam int CMPW_R = (RIW + 1 > WR_IDX_W + 1) ? RIW + 1 : WR_IDX_W + 1;
  localparam int CMPW_C = (CIW + 1 > WR_IDX_W + 1) ? CIW + 1 : WR_IDX_W + 1;

  localparam logic [WW-1:0]  ONE       = WW'(1) << FRAC_BITS;
  localparam logic [CBW-1:0] HALF_UNIT = CBW'(1) << (2 * FRAC_BITS - 1);

  // Configuration registers.
  logic [CFG_W-1:0] rows_cfg_r, cols_cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r <= CFG_SIZE_RESET;
      cols_cfg_r <= CFG_SIZE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_STORED_ROWS: rows_cfg_r <= cfg_wdata;
        CFG_STORED_COLS: cols_cfg_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Pipeline hold chain.
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic adv1, adv2, adv3, adv4, adv_out;

  assign adv_out  = !out_valid_r || !out_stall;
  assign adv4     = !v4_r || adv_out;
  assign adv3     = !v3_r || adv4;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_stall = !adv1;

  // Stage 1: coordinate split and write decode.
  logic [RIW-1:0] qr_nxt;
  logic [CIW-1:0] qc_nxt;
  logic [WW-1:0]  a_nxt, b_nxt;
  logic [RIW-1:0] wr_row_i;
  logic [CIW-1:0] wr_col_i;
  logic           wr_ok_nxt;

  bps_axis #(.MAX_SIZE(MAX_ROWS), .FRAC_BITS(FRAC_BITS), .IDX_W(RIW)) u_axis_row (
    .coord(in_sample_row), .size_cfg(rows_cfg_r), .q(qr_nxt), .w(a_nxt)
  );

  bps_axis #(.MAX_SIZE(MAX_COLS), .FRAC_BITS(FRAC_BITS), .IDX_W(CIW)) u_axis_col (
    .coord(in_sample_col), .size_cfg(cols_cfg_r), .q(qc_nxt), .w(b_nxt)
  );

  assign wr_row_i  = RIW'(in_write_row);
  assign wr_col_i  = CIW'(in_write_col);
  assign wr_ok_nxt = (CMPW_R'(in_write_row) < CMPW_R'(MAX_ROWS)) &&
                     (CMPW_C'(in_write_col) < CMPW_C'(MAX_COLS));

  logic           op1_r, wr_ok1_r, wr_rpar1_r, wr_cpar1_r;
  logic [RHW-1:0] wr_rhalf1_r;
  logic [CHW-1:0] wr_chalf1_r;
  logic [PIX_W-1:0] wdata1_r;
  logic [RIW-1:0] qr1_r;
  logic [CIW-1:0] qc1_r;
  logic [WW-1:0]  a1_r, b1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      op1_r       <= in_opcode[0];
      wr_ok1_r    <= wr_ok_nxt;
      wr_rpar1_r  <= wr_row_i[0];
      wr_cpar1_r  <= wr_col_i[0];
      wr_rhalf1_r <= RHW'(wr_row_i >> 1);
      wr_chalf1_r <= CHW'(wr_col_i >> 1);
      wdata1_r    <= in_write_value;
      qr1_r       <= qr_nxt;
      qc1_r       <= qc_nxt;
      a1_r        <= a_nxt;
      b1_r        <= b_nxt;
    end
  end

  // Stage 2: bank access. The even-parity bank holds whichever of q and q+1 is even.
  logic           is_sample1, is_write1;
  logic [RHW-1:0] rhalf [2];
  logic [CHW-1:0] chalf [2];
  logic [3:0]     bank_we;
  logic [AW-1:0]  bank_addr [4];
  logic [PIX_W-1:0] bank_rdata [4];

  assign is_sample1 = (opcode_t'(op1_r) == OP_SAMPLE);
  assign is_write1  = (opcode_t'(op1_r) == OP_WRITE);

  assign rhalf[0] = RHW'((qr1_r >> 1) + RIW'(qr1_r[0]));
  assign rhalf[1] = RHW'(qr1_r >> 1);
  assign chalf[0] = CHW'((qc1_r >> 1) + CIW'(qc1_r[0]));
  assign chalf[1] = CHW'(qc1_r >> 1);

  for (genvar k = 0; k < 4; k++) begin : g_bank
    localparam logic PR = 1'(k / 2);
    localparam logic PC = 1'(k % 2);

    assign bank_we[k] = v1_r && is_write1 && wr_ok1_r && adv2 &&
                        (wr_rpar1_r == PR) && (wr_cpar1_r == PC);
    assign bank_addr[k] = is_write1 ? {wr_rhalf1_r, wr_chalf1_r}
                                    : {rhalf[k / 2], chalf[k % 2]};

    bps_bank #(.AW(AW)) u_bank (
      .clk  (clk),
      .en   (adv2),
      .we   (bank_we[k]),
      .addr (bank_addr[k]),
      .wdata(wdata1_r),
      .rdata(bank_rdata[k])
    );
  end

  logic          qr0_2_r, qc0_2_r;
  logic [WW-1:0] a2_r, b2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv2) begin
      v2_r <= v1_r && is_sample1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      qr0_2_r <= qr1_r[0];
      qc0_2_r <= qc1_r[0];
      a2_r    <= a1_r;
      b2_r    <= b1_r;
    end
  end

  // Stage 3: blend along the row axis, one result per column parity.
  logic [RBW-1:0] rblend_nxt [2];
  logic [RBW-1:0] rblend3_r  [2];
  logic           qc0_3_r;
  logic [WW-1:0]  b3_r;

  always_comb begin
    for (int pc = 0; pc < 2; pc++) begin
      rblend_nxt[pc] = RBW'(ONE - a2_r) * RBW'(bank_rdata[{qr0_2_r, pc[0]}]) +
                       RBW'(a2_r) * RBW'(bank_rdata[{~qr0_2_r, pc[0]}]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      rblend3_r[0] <= rblend_nxt[0];
      rblend3_r[1] <= rblend_nxt[1];
      qc0_3_r      <= qc0_2_r;
      b3_r         <= b2_r;
    end
  end

  // Stage 4: blend along the column axis.
  logic [CBW-1:0] cblend_nxt, cblend4_r;

  assign cblend_nxt = CBW'(ONE - b3_r) * CBW'(rblend3_r[qc0_3_r]) +
                      CBW'(b3_r) * CBW'(rblend3_r[~qc0_3_r]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv4) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      cblend4_r <= cblend_nxt;
    end
  end

  // Output register: round half up to a byte.
  logic [CBW-1:0]   rounded;
  logic [PIX_W-1:0] out_value_r;

  assign rounded = cblend4_r + HALF_UNIT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv_out) begin
      out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out) begin
      out_value_r <= rounded[2 * FRAC_BITS +: PIX_W];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample_value = out_value_r;

  // Checks.
  a_bank_we_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(bank_we))
    else $error("more than one bank written in a cycle");

  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && is_write1 && adv2 |=> !v2_r)
    else $error("write transaction entered the read pipeline");

  a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && is_sample1 |-> (a1_r <= ONE) && (b1_r <= ONE))
    else $error("interpolation weight above one");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> v1_r && v2_r && v3_r && v4_r && out_valid_r && out_stall)
    else $error("input stalled while the pipeline has a free stage");

  a_bank_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && !adv2 |=> $stable(bank_rdata[0]) && $stable(bank_rdata[3]))
    else $error("bank read data changed while stage two was held");

endmodule

>>> sv/bps_axis.sv
// Splits one sample coordinate into a first neighbour index and a weight.
// Depends on bps_pkg for the coordinate and configuration widths.
`timescale 1ns / 1ps

module bps_axis import bps_pkg::*; #(
  parameter int MAX_SIZE  = MAX_ROWS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int IDX_W     = $clog2(MAX_ROWS_DEF)
) (
  input  logic [COORD_W-1:0] coord,
  input  logic [CFG_W-1:0]   size_cfg,
  output logic [IDX_W-1:0]   q,
  output logic [FRAC_BITS:0] w
);

  localparam int TW     = COORD_W + 1;
  localparam int FW     = TW - FRAC_BITS;
  localparam int SZ_MAX = $clog2(MAX_SIZE + 1);
  localparam int SZ_W   = (SZ_MAX > CFG_W) ? SZ_MAX : CFG_W;
  localparam int CW     = (FW > SZ_W) ? FW : SZ_W;

  localparam logic signed [TW-1:0]    THREE_HALF = TW'(3) << (FRAC_BITS - 1);
  localparam logic        [FRAC_BITS:0] ONE      = (FRAC_BITS + 1)'(1) << FRAC_BITS;

  logic [SZ_W-1:0]      size_eff;
  logic [SZ_W-1:0]      last_q;
  logic signed [TW-1:0] t;
  logic [FW-1:0]        fl;

  always_comb begin
    // Sizes outside 2..MAX_SIZE act as the nearest bound.
    if (SZ_W'(size_cfg) < SZ_W'(2)) begin
      size_eff = SZ_W'(2);
    end else if (SZ_W'(size_cfg) > SZ_W'(MAX_SIZE)) begin
      size_eff = SZ_W'(MAX_SIZE);
    end else begin
      size_eff = SZ_W'(size_cfg);
    end
    last_q = size_eff - SZ_W'(2);

    t  = $signed({coord[COORD_W-1], coord}) + THREE_HALF;
    fl = t[TW-1:FRAC_BITS];

    if (t[TW-1]) begin
      q = '0;
      w = '0;
    end else if (CW'(fl) > CW'(last_q)) begin
      q = IDX_W'(last_q);
      w = ONE;
    end else begin
      q = IDX_W'(fl);
      w = {1'b0, t[FRAC_BITS-1:0]};
    end
  end

endmodule

>>> sv/bps_bank.sv
// One single-port pixel bank holding a quarter of the image by row and column parity.
// Depends on bps_pkg for the pixel width.
`timescale 1ns / 1ps

module bps_bank import bps_pkg::*; #(
  parameter int AW = 16
) (
  input  logic             clk,
  input  logic             en,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [PIX_W-1:0] wdata,
  output logic [PIX_W-1:0] rdata
);

  logic [PIX_W-1:0] mem [2**AW];
  logic [PIX_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> bench/tb_bilinear_pixel_sampler.sv
// Self-checking testbench for bilinear_pixel_sampler: loads pixels, requests samples
// and checks every blended byte against an in-bench image copy. Depends on bps_pkg.
`timescale 1ns / 1ps

module tb_bilinear_pixel_sampler;
  import bps_pkg::*;

  localparam int ONE       = 1 << FRAC_BITS_DEF;
  localparam int HALF_STEP = 3 << (FRAC_BITS_DEF - 1);
  localparam int ROUND_ADD = 1 << (2 * FRAC_BITS_DEF - 1);
  localparam int NUM_SIZES = 8;
  localparam int PHASE_ITEMS = 55;

  typedef struct packed {
    opcode_t              op;
    logic [WR_IDX_W-1:0]  wr_row;
    logic [WR_IDX_W-1:0]  wr_col;
    logic [PIX_W-1:0]     wr_value;
    logic [COORD_W-1:0]   smp_row;
    logic [COORD_W-1:0]   smp_col;
  } sampler_item_t;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [0:0]          in_opcode = OP_WRITE;
  logic [WR_IDX_W-1:0] in_write_row = '0;
  logic [WR_IDX_W-1:0] in_write_col = '0;
  logic [PIX_W-1:0]    in_write_value = '0;
  logic [COORD_W-1:0]  in_sample_row = '0;
  logic [COORD_W-1:0]  in_sample_col = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [PIX_W-1:0]    out_sample_value;
  logic                cfg_we = 1'b0;
  logic [0:0]          cfg_index = CFG_STORED_ROWS;
  logic [CFG_W-1:0]    cfg_wdata = '0;

  bilinear_pixel_sampler dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_write_row     (in_write_row),
    .in_write_col     (in_write_col),
    .in_write_value   (in_write_value),
    .in_sample_row    (in_sample_row),
    .in_sample_col    (in_sample_col),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample_value (out_sample_value),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  // Image copy seen by accepted transactions, and the set of pixels that the
  // generated stream will have written by the time each item is applied.
  logic [PIX_W-1:0] image_copy [MAX_ROWS_DEF][MAX_COLS_DEF];
  bit               pixel_planned [MAX_ROWS_DEF][MAX_COLS_DEF];
  logic [CFG_W-1:0] rows_setting = CFG_SIZE_RESET;
  logic [CFG_W-1:0] cols_setting = CFG_SIZE_RESET;

  sampler_item_t    item_queue [$];
  logic [PIX_W-1:0] expected_blends [$];
  sampler_item_t    offered;

  int unsigned items_queued = 0;
  int unsigned items_accepted = 0;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  int unsigned stall_mode = 0;
  int unsigned mode_left = 0;
  int unsigned hold_left = 0;
  int unsigned holds_done = 0;
  int unsigned error_count = 0;
  int unsigned writes_seen = 0;
  int unsigned samples_seen = 0;
  int unsigned low_clamps = 0;
  int unsigned high_clamps = 0;
  int unsigned size_settings = 0;

  logic [CFG_W-1:0] row_sizes [NUM_SIZES] = '{10'd2, 10'd0, 10'd1, 10'd1023,
                                              10'd7, 10'd512, 10'd37, 10'd512};
  logic [CFG_W-1:0] col_sizes [NUM_SIZES] = '{10'd2, 10'd1023, 10'd5, 10'd0,
                                              10'd300, 10'd2, 10'd512, 10'd512};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("tb_bilinear_pixel_sampler NOT OK");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (error_count < 40) $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  function automatic int effective_size(input logic [CFG_W-1:0] raw, input int limit);
    if (raw < 2) return 2;
    if (raw > limit) return limit;
    return int'(raw);
  endfunction

  // Splits one coordinate into the first neighbour and its weight. side is -1
  // when the coordinate lies below the image, +1 beyond it, 0 otherwise.
  function automatic void split_axis(input logic signed [COORD_W-1:0] coord, input int span,
                                     output int first, output int weight, output int side);
    int t;
    t = int'(coord) + HALF_STEP;
    if (t < 0) begin
      first = 0;
      weight = 0;
      side = -1;
    end else if (t / ONE > span) begin
      first = span;
      weight = ONE;
      side = 1;
    end else begin
      first = t / ONE;
      weight = t % ONE;
      side = 0;
    end
  endfunction

  function automatic logic [PIX_W-1:0] blend_pixels(input int r0, input int c0,
                                                    input int a, input int b);
    longint unsigned acc;
    acc = longint'((ONE - a) * (ONE - b)) * image_copy[r0][c0]
        + longint'(a * (ONE - b)) * image_copy[r0 + 1][c0]
        + longint'((ONE - a) * b) * image_copy[r0][c0 + 1]
        + longint'(a * b) * image_copy[r0 + 1][c0 + 1];
    acc = (acc + ROUND_ADD) >> (2 * FRAC_BITS_DEF);
    return acc[PIX_W-1:0];
  endfunction

  // Applies one accepted transaction to the image copy or queues its blend.
  task automatic track_transaction(input sampler_item_t it);
    int qr, qc, a, b, sr, sc;
    if (it.op == OP_WRITE) begin
      image_copy[it.wr_row][it.wr_col] = it.wr_value;
      writes_seen++;
    end else begin
      split_axis(it.smp_row, effective_size(rows_setting, MAX_ROWS_DEF) - 2, qr, a, sr);
      split_axis(it.smp_col, effective_size(cols_setting, MAX_COLS_DEF) - 2, qc, b, sc);
      expected_blends = {expected_blends, blend_pixels(qr, qc, a, b)};
      samples_seen++;
      if (sr < 0 || sc < 0) low_clamps++;
      if (sr > 0 || sc > 0) high_clamps++;
    end
  endtask

  task automatic queue_write(input int r, input int c, input int value);
    sampler_item_t it;
    it.op = OP_WRITE;
    it.wr_row = WR_IDX_W'(r);
    it.wr_col = WR_IDX_W'(c);
    it.wr_value = PIX_W'(value);
    it.smp_row = COORD_W'($urandom);
    it.smp_col = COORD_W'($urandom);
    pixel_planned[r][c] = 1'b1;
    item_queue = {item_queue, it};
    items_queued++;
  endtask

  // Writes any of the four neighbours not yet written, then requests the sample.
  task automatic queue_sample(input logic [COORD_W-1:0] row_c, input logic [COORD_W-1:0] col_c);
    int qr, qc, a, b, sr, sc;
    sampler_item_t it;
    split_axis(row_c, effective_size(rows_setting, MAX_ROWS_DEF) - 2, qr, a, sr);
    split_axis(col_c, effective_size(cols_setting, MAX_COLS_DEF) - 2, qc, b, sc);
    for (int dr = 0; dr < 2; dr++)
      for (int dc = 0; dc < 2; dc++)
        if (!pixel_planned[qr + dr][qc + dc])
          queue_write(qr + dr, qc + dc, $urandom_range(255, 0));
    it.op = OP_SAMPLE;
    it.wr_row = WR_IDX_W'($urandom);
    it.wr_col = WR_IDX_W'($urandom);
    it.wr_value = PIX_W'($urandom);
    it.smp_row = row_c;
    it.smp_col = col_c;
    item_queue = {item_queue, it};
    items_queued++;
  endtask

  function automatic logic [COORD_W-1:0] pick_coord(input int span);
    int t;
    int unsigned mode;
    mode = $urandom_range(9, 0);
    if (mode < 5) t = $urandom_range(span * ONE + ONE - 1, 0);
    else if (mode == 5) t = -int'($urandom_range((1 << (COORD_W - 1)) - HALF_STEP, 1));
    else if (mode == 6) t = $urandom_range((1 << (COORD_W - 1)) - 1 + HALF_STEP, (span + 1) * ONE);
    else if (mode == 7) t = $urandom_range(span + 1, 0) * ONE;
    else return COORD_W'($urandom);
    return COORD_W'(t - HALF_STEP);
  endfunction

  task automatic write_size(input cfg_index_t idx, input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_STORED_ROWS) rows_setting = value;
    else cols_setting = value;
  endtask

  // Waits until every queued transaction is accepted and every blend has come back.
  task automatic drain(input int unsigned settle);
    int unsigned waited;
    waited = 0;
    @(negedge clk);
    while ((items_accepted != items_queued || expected_blends.size() != 0) && waited < 100000) begin
      @(negedge clk);
      waited++;
    end
    repeat (settle) @(negedge clk);
  endtask

  always @(posedge clk) begin : driver
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        track_transaction(offered);
        items_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (item_queue.size() > 0) begin
          offered = item_queue.pop_front();
          in_opcode <= offered.op;
          in_write_row <= offered.wr_row;
          in_write_col <= offered.wr_col;
          in_write_value <= offered.wr_value;
          in_sample_row <= offered.smp_row;
          in_sample_col <= offered.smp_col;
          in_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(24, 1);
            gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_blends.size() == 0)
          report_mismatch($sformatf("unexpected sample_value %0d", out_sample_value));
        else if (out_sample_value !== expected_blends[0])
          report_mismatch($sformatf("sample_value got %0d expected %0d",
                                    out_sample_value, expected_blends.pop_front()));
        else
          void'(expected_blends.pop_front());
      end
      // Two long hold-offs while the sender keeps offering, to back up the pipeline.
      if (hold_left == 0 && holds_done < 2 && items_accepted >= (holds_done + 1) * 150) begin
        hold_left = 90;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(3, 0);
          mode_left = $urandom_range(80, 10);
        end else begin
          mode_left--;
        end
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(3, 0) == 0);
          2: out_stall <= ($urandom_range(3, 0) != 0);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  initial begin
    int unsigned target;
    // Corner pixels for the directed samples at the reset size of 512 x 512.
    queue_write(0, 0, 255);
    queue_write(0, 1, 0);
    queue_write(1, 0, 0);
    queue_write(1, 1, 255);
    queue_sample(COORD_W'(-HALF_STEP), COORD_W'(-HALF_STEP));
    queue_sample(COORD_W'(-HALF_STEP + ONE / 2), COORD_W'(-HALF_STEP + ONE / 2));
    queue_sample(COORD_W'(-(1 << (COORD_W - 1))), COORD_W'(-(1 << (COORD_W - 1))));
    queue_write(510, 510, 0);
    queue_write(510, 511, 0);
    queue_write(511, 510, 0);
    queue_write(511, 511, 255);
    queue_sample(COORD_W'((1 << (COORD_W - 1)) - 1), COORD_W'((1 << (COORD_W - 1)) - 1));
    queue_sample(COORD_W'(-(1 << (COORD_W - 1))), COORD_W'((1 << (COORD_W - 1)) - 1));
    queue_sample(COORD_W'(-255), COORD_W'(-129));
    queue_write(0, 0, 0);
    queue_sample(COORD_W'(-HALF_STEP), COORD_W'(-HALF_STEP));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p <= NUM_SIZES; p++) begin
      if (p > 0) begin
        drain(8);
        write_size(CFG_STORED_ROWS, row_sizes[p - 1]);
        write_size(CFG_STORED_COLS, col_sizes[p - 1]);
      end
      target = items_queued + PHASE_ITEMS;
      while (items_queued < target) begin
        if ($urandom_range(99, 0) < 70)
          queue_sample(pick_coord(effective_size(rows_setting, MAX_ROWS_DEF) - 2),
                       pick_coord(effective_size(cols_setting, MAX_COLS_DEF) - 2));
        else if ($urandom_range(1, 0) == 0)
          queue_write($urandom_range(effective_size(rows_setting, MAX_ROWS_DEF) - 1, 0),
                      $urandom_range(effective_size(cols_setting, MAX_COLS_DEF) - 1, 0),
                      $urandom_range(255, 0));
        else
          queue_write($urandom_range(MAX_ROWS_DEF - 1, 0), $urandom_range(MAX_COLS_DEF - 1, 0),
                      $urandom_range(255, 0));
      end
      size_settings++;
    end

    drain(12);
    if (expected_blends.size() != 0)
      report_mismatch($sformatf("%0d expected samples never returned", expected_blends.size()));

    $display("Covered %0d pixel writes and %0d samples across %0d image sizes.",
             writes_seen, samples_seen, size_settings);
    $display("Samples clamped below the image: %0d, beyond it: %0d; mismatches: %0d.",
             low_clamps, high_clamps, error_count);
    if (error_count == 0) begin
      $display("tb_bilinear_pixel_sampler OK");
    end else begin
      $display("tb_bilinear_pixel_sampler NOT OK");
    end
    $finish;
  end

endmodule
